/* design/exlfsr_pkg.sv */
// Shared constants and feedback helpers for the XNOR LFSR keystream engine.
package exlfsr_pkg;

  localparam int WORD_W   = 32;
  localparam int STEP_W   = 10;
  localparam int ACTION_W = 2;
  localparam int IN_W     = 48;

  localparam int MAX_STEPS = 1023;
  localparam logic [STEP_W-1:0] MAX_STEPS_C = STEP_W'(MAX_STEPS);

  localparam logic [ACTION_W-1:0] ACT_SEED    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DESCRAM = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  // Feedback for right-shift steps: inverted XOR of bits 0, 7, 15 and 23.
  function automatic logic fb_right(input word_t w);
    fb_right = ~(w[0] ^ w[7] ^ w[15] ^ w[23]);
  endfunction

  // Feedback for left-shift steps: inverted XOR of bits 31, 24, 16 and 8.
  function automatic logic fb_left(input word_t w);
    fb_left = ~(w[31] ^ w[24] ^ w[16] ^ w[8]);
  endfunction

  function automatic word_t rev32(input word_t v);
    word_t r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = v[WORD_W-1-i];
    end
    rev32 = r;
  endfunction

endpackage

/* design/exnor_lfsr_unlock_scrambler.sv */
// Top level of the XNOR LFSR keystream engine: one shared shift step under a sequencer.
//
// Usage:
//   Slave channel (s_*) takes one request: tuser holds the action (0 seed,
//   1 descramble then advance, 2 advance only, 3 no change), tdata holds
//   data_word in bits 31:0 and step_count in bits 41:32.
//   Master channel (m_*) returns one result word per request.
// Timing:
//   A request with step count n (saturated at MAX_STEPS) takes n steps in
//   the single-bit shift unit, then a final step applying the last feedback
//   bit (and the bit reversal for a seed), after which m_tvalid rises.
//   Action 3 answers on the next cycle. The shift loop sets the rate, and
//   a new request is taken only after the last result is delivered.
//   s_tready is high only while no request is in flight.
// Reset:
//   rst (synchronous, active high) clears the keystream to zero and drops
//   any request in flight.
// Stall:
//   When m_tready is low the result holds in the output register and no
//   new request is taken until it is delivered.
module exnor_lfsr_unlock_scrambler
  import exlfsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,   // [31:0] data_word, [41:32] step_count, [47:42] zero
  input  logic [ACTION_W-1:0] s_tuser,   // [1:0] action
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [WORD_W-1:0]   m_tdata    // [31:0] result_word
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state;
  logic [ACTION_W-1:0] act;
  logic [STEP_W-1:0]   count;
  word_t               work;
  word_t               keystream;
  word_t               result;

  logic                accept;
  word_t               in_word;
  logic [STEP_W-1:0]   in_steps;
  logic [STEP_W-1:0]   steps_clamped;
  word_t               step_out;
  word_t               seed_final;
  word_t               adv_final;

  assign accept   = s_tvalid && s_tready;
  assign in_word  = s_tdata[WORD_W-1:0];
  assign in_steps = s_tdata[WORD_W+STEP_W-1:WORD_W];
  assign steps_clamped = (in_steps > MAX_STEPS_C) ? MAX_STEPS_C : in_steps;

  // Shared single-step unit: right shift feeding bit 30 for a seed, left
  // shift feeding bit 1 for an advance.
  always_comb begin
    if (act == ACT_SEED) begin
      step_out = {1'b0, work[31] | fb_right(work), work[30:1]};
    end else begin
      step_out = {work[30:1], work[0] | fb_left(work), 1'b0};
    end
  end

  // Final feedback bit, plus the bit reversal on the seed path.
  assign seed_final = rev32({work[31] | fb_right(work), work[30:0]});
  assign adv_final  = {work[31:1], work[0] | fb_left(work)};

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_DONE);
  assign m_tdata  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      keystream <= '0;
      act       <= ACT_NONE;
      count     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            act   <= s_tuser;
            count <= steps_clamped;
            if (s_tuser == ACT_SEED) begin
              work  <= in_word;
              state <= ST_RUN;
            end else if (s_tuser == ACT_NONE) begin
              // Unused code: report the keystream, leave it alone.
              result <= keystream;
              state  <= ST_DONE;
            end else begin
              work   <= keystream;
              result <= in_word ^ keystream;
              state  <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (count != '0) begin
            // Advance one shift step.
            work  <= step_out;
            count <= count - STEP_W'(1);
          end else begin
            if (act == ACT_SEED) begin
              keystream <= seed_final;
              result    <= seed_final;
            end else begin
              keystream <= adv_final;
              if (act == ACT_ADVANCE) begin
                result <= adv_final;
              end
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold the result until the receiver takes it.
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The block never takes a request while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request accepted while a result is pending");

  // Each running cycle with steps left takes exactly one step off the count.
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && count != '0) |=> (count == $past(count) - STEP_W'(1)))
    else $error("step counter did not advance by one");

  // An unused action answers on the next cycle with the unchanged keystream.
  a_none_echo: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == ACT_NONE) |=>
      (m_tvalid && m_tdata == $past(keystream) && keystream == $past(keystream)))
    else $error("unused action changed or misreported the keystream");

  // While a result waits, the keystream stays put.
  a_ks_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> $stable(keystream))
    else $error("keystream moved while a result was pending");

endmodule
